@@ hdl/tsce_pkg.sv @@
`timescale 1ns / 1ps

package tsce_pkg;

  localparam int NUM_TERMS_DEF = 10;

  localparam int ARG_W     = 32;
  localparam int X_W       = 31;  // |x| after clamping, up to 2^30
  localparam int X_FRAC    = 28;
  localparam int TERM_FRAC = 40;
  localparam int TERM_W    = 44;  // term magnitude, below 16.0 in q.40
  localparam int MAG_W     = 48;  // dividend magnitude, below 256.0 in q.40
  localparam int HALF_W    = MAG_W / 2;
  localparam int SUM_W     = 48;
  localparam int DIV_W     = 10;  // largest divisor is 18*19 at the default term count
  localparam int REM_W     = DIV_W + 1;
  localparam int VAL_W     = 32;
  localparam int ROUND_SH  = TERM_FRAC - 24;

  localparam logic [1:0] OP_SIN  = 2'd0;
  localparam logic [1:0] OP_COS  = 2'd1;
  localparam logic [1:0] OP_EXP  = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam logic signed [ARG_W-1:0] ARG_MAX = 32'sh4000_0000;
  localparam logic signed [ARG_W-1:0] ARG_MIN = 32'shC000_0000;
  localparam logic [X_W-1:0]          X_LIMIT = 31'h4000_0000;
  localparam logic [TERM_W-1:0]       ONE_TERM = TERM_W'(1) << TERM_FRAC;

  typedef struct packed {
    logic [1:0]              opcode;
    logic signed [ARG_W-1:0] arg;
  } in_beat_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    saturated;
  } out_beat_t;

  // running state of one item between term sections
  typedef struct packed {
    logic [1:0]              op;
    logic [X_W-1:0]          xmag;
    logic                    xneg;
    logic [TERM_W-1:0]       tmag;
    logic                    tneg;
    logic signed [SUM_W-1:0] sum;  // excludes the current term
  } term_beat_t;

endpackage

@@ hdl/taylor_series_sin_cos_exp.sv @@
`timescale 1ns / 1ps
// channel  dir  handshake            payload
// in       in   in_valid, in_stall   in_data  : opcode, arg (q3.28)
// out      out  out_valid, out_stall out_data : value (q7.24), saturated
//
// fully pipelined, one beat per cycle while in_stall is low; a result passes
// setup, nine stages for each term after the first, three rounding stages
// and the output register
// reset clears only the valid bits; no clearing pass
// a skid register behind the output lets one more result land while out is
// stalled; in_stall is that skid being full, and it freezes the whole pipe

module taylor_series_sin_cos_exp #(
  parameter int NUM_TERMS = tsce_pkg::NUM_TERMS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tsce_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tsce_pkg::out_beat_t out_data
);

  localparam int AW  = tsce_pkg::ARG_W;
  localparam int XW  = tsce_pkg::X_W;
  localparam int TW  = tsce_pkg::TERM_W;
  localparam int SW  = tsce_pkg::SUM_W;
  localparam int VW  = tsce_pkg::VAL_W;
  localparam int RSH = tsce_pkg::ROUND_SH;
  localparam int RMW = SW + 1 - RSH;
  localparam int SW1 = SW + 1;

  localparam logic [SW:0]    ROUND_HALF = SW1'(1) << (RSH - 1);
  localparam logic [RMW-1:0] LIM_NEG    = RMW'(1) << (VW - 1);
  localparam logic [RMW-1:0] LIM_POS    = LIM_NEG - RMW'(1);

  logic en;

  logic                 in_v_r;
  tsce_pkg::in_beat_t   in_r;
  logic signed [AW-1:0] arg_s;
  logic [AW-1:0]        arg_abs;
  logic [XW-1:0]        xmag;
  logic                 pr_v_r;
  tsce_pkg::term_beat_t pr_r;
  tsce_pkg::term_beat_t pr_nxt;

  logic [NUM_TERMS-1:0] chain_v;
  tsce_pkg::term_beat_t chain_beat [NUM_TERMS];
  tsce_pkg::term_beat_t last;

  logic [2:0]           fv_r;
  logic [1:0]           f1_op_r, f2_op_r, f3_op_r;
  logic signed [SW-1:0] f1_sum_r;
  logic                 f2_neg_r, f3_neg_r;
  logic [SW-1:0]        f2_abs_r;
  logic [SW:0]          rnd;
  logic [RMW-1:0]       f3_mag_r;

  logic [RMW-1:0]       lim;
  logic [RMW-1:0]       mag_c;
  logic                 sat;
  tsce_pkg::out_beat_t  res_nxt;

  logic                 out_v_r, skid_v_r;
  tsce_pkg::out_beat_t  out_r, skid_r;
  logic                 load_out, arrive;

  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;

  // clamp x to [-4, 4] and build the first term
  assign arg_s   = in_r.arg;
  assign arg_abs = (arg_s ^ {AW{arg_s[AW-1]}}) + AW'(arg_s[AW-1]);
  assign xmag    = (arg_s > tsce_pkg::ARG_MAX || arg_s < tsce_pkg::ARG_MIN)
                   ? tsce_pkg::X_LIMIT : arg_abs[XW-1:0];

  always_comb begin
    pr_nxt.op   = in_r.opcode;
    pr_nxt.xmag = xmag;
    pr_nxt.xneg = arg_s[AW-1];
    pr_nxt.sum  = '0;
    if (in_r.opcode == tsce_pkg::OP_SIN) begin
      pr_nxt.tmag = TW'(xmag) << (tsce_pkg::TERM_FRAC - tsce_pkg::X_FRAC);
      pr_nxt.tneg = arg_s[AW-1];
    end else begin
      pr_nxt.tmag = tsce_pkg::ONE_TERM;
      pr_nxt.tneg = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      pr_v_r <= 1'b0;
      fv_r   <= '0;
    end else if (en) begin
      in_v_r <= in_valid;
      pr_v_r <= in_v_r;
      fv_r   <= {fv_r[1:0], chain_v[NUM_TERMS-1]};
    end
  end

  assign chain_v[0]    = pr_v_r;
  assign chain_beat[0] = pr_r;

  for (genvar g = 1; g < NUM_TERMS; g++) begin : g_term
    tsce_term #(
      .TERM_IDX (g)
    ) u_term (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (chain_v[g-1]),
      .in_beat   (chain_beat[g-1]),
      .out_valid (chain_v[g]),
      .out_beat  (chain_beat[g])
    );
  end

  assign last = chain_beat[NUM_TERMS-1];
  assign rnd  = {1'b0, f2_abs_r} + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (en) begin
      in_r <= in_data;
      pr_r <= pr_nxt;

      f1_op_r  <= last.op;
      f1_sum_r <= last.sum + (SW'(last.tmag) ^ {SW{last.tneg}}) + SW'(last.tneg);

      f2_op_r  <= f1_op_r;
      f2_neg_r <= f1_sum_r[SW-1];
      f2_abs_r <= (f1_sum_r ^ {SW{f1_sum_r[SW-1]}}) + SW'(f1_sum_r[SW-1]);

      // round magnitude half up into q.24
      f3_op_r  <= f2_op_r;
      f3_neg_r <= f2_neg_r;
      f3_mag_r <= rnd[SW:RSH];
    end
  end

  assign lim   = f3_neg_r ? LIM_NEG : LIM_POS;
  assign sat   = f3_mag_r > lim;
  assign mag_c = sat ? lim : f3_mag_r;

  always_comb begin
    if (f3_op_r == tsce_pkg::OP_NONE) begin
      res_nxt.value     = '0;
      res_nxt.saturated = 1'b0;
    end else begin
      res_nxt.value     = f3_neg_r ? VW'(~mag_c + RMW'(1)) : VW'(mag_c);
      res_nxt.saturated = sat;
    end
  end

  // output register with skid
  assign load_out = !out_v_r || !out_stall;
  assign arrive   = en && fv_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (load_out) begin
      out_v_r  <= skid_v_r || arrive;
      skid_v_r <= 1'b0;
    end else if (arrive) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r <= skid_v_r ? skid_r : res_nxt;
    end else if (arrive) begin
      skid_r <= res_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

@@ hdl/tsce_term.sv @@
`timescale 1ns / 1ps

module tsce_term #(
  parameter int TERM_IDX = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  tsce_pkg::term_beat_t in_beat,
  output logic                 out_valid,
  output tsce_pkg::term_beat_t out_beat
);

  localparam int MW   = tsce_pkg::MAG_W;
  localparam int HW   = tsce_pkg::HALF_W;
  localparam int XW   = tsce_pkg::X_W;
  localparam int TW   = tsce_pkg::TERM_W;
  localparam int SW   = tsce_pkg::SUM_W;
  localparam int DW   = tsce_pkg::DIV_W;
  localparam int RW   = tsce_pkg::REM_W;
  localparam int PW   = HW + XW;
  localparam int PW1  = PW + 1;
  localparam int QW   = 2 * HW;
  localparam int MIDW = QW + 2;
  localparam int PRW  = RW + DW;
  localparam int NSTG = 9;

  localparam int DIV_EXP = TERM_IDX;
  localparam int DIV_SIN = 2 * TERM_IDX * (2 * TERM_IDX + 1);
  localparam int DIV_COS = (2 * TERM_IDX - 1) * (2 * TERM_IDX);

  // floor((2^MW - 1) / d) keeps the quotient estimate within one of exact
  localparam logic [MW-1:0] MAG_ONES = '1;
  localparam logic [MW-1:0] RCP_EXP  = MAG_ONES / MW'(DIV_EXP);
  localparam logic [MW-1:0] RCP_SIN  = MAG_ONES / MW'(DIV_SIN);
  localparam logic [MW-1:0] RCP_COS  = MAG_ONES / MW'(DIV_COS);

  typedef struct packed {
    logic [1:0]              op;
    logic [XW-1:0]           xmag;
    logic                    xneg;
    logic                    tneg;
    logic signed [SW-1:0]    sum;
  } carry_t;

  // (hi*2^HW + lo) >> X_FRAC
  function automatic logic [MW-1:0] fold_mul(input logic [PW-1:0] lo,
                                             input logic [PW-1:0] hi);
    logic [PW:0] s;
    s = {1'b0, hi} + PW1'(lo >> HW);
    return MW'(s >> (tsce_pkg::X_FRAC - HW));
  endfunction

  logic [NSTG-1:0] v_r;
  carry_t          c_r [1:NSTG];
  carry_t          c1_nxt;

  logic [MW-1:0]   m_in;
  logic [PW-1:0]   s1_lo_r, s1_hi_r;
  logic [MW-1:0]   s2_m_r;
  logic [MW-1:0]   s3_m_r;
  logic [PW-1:0]   s3_lo_r, s3_hi_r;
  logic [MW-1:0]   s4_m_r;
  logic [MW-1:0]   rcp;
  logic [DW-1:0]   div;
  logic [MW-1:0]   s5_m_r;
  logic [DW-1:0]   s5_d_r;
  logic [QW-1:0]   s5_ll_r, s5_lh_r, s5_hl_r, s5_hh_r;
  logic [MW-1:0]   s6_m_r;
  logic [DW-1:0]   s6_d_r;
  logic [QW-1:0]   s6_hh_r;
  logic [MIDW-1:0] s6_mid_r;
  logic [MW-1:0]   s7_m_r;
  logic [DW-1:0]   s7_d_r;
  logic [MW-1:0]   s7_q0_r;
  logic [PRW-1:0]  qd_low;
  logic [MW-1:0]   s8_q0_r;
  logic [DW-1:0]   s8_d_r;
  logic [RW-1:0]   s8_r_r;
  logic [MW-1:0]   q_fix;
  logic [TW-1:0]   tmag_r;

  assign m_in = MW'(in_beat.tmag);

  always_comb begin
    c1_nxt.op   = in_beat.op;
    c1_nxt.xmag = in_beat.xmag;
    c1_nxt.xneg = in_beat.xneg;
    c1_nxt.sum  = in_beat.sum + (SW'(in_beat.tmag) ^ {SW{in_beat.tneg}})
                  + SW'(in_beat.tneg);
    // exp picks up the sign of x, sine and cosine alternate
    c1_nxt.tneg = (in_beat.op == tsce_pkg::OP_EXP) ? (in_beat.tneg ^ in_beat.xneg)
                                                   : !in_beat.tneg;
  end

  always_comb begin
    unique case (c_r[4].op)
      tsce_pkg::OP_SIN: begin
        rcp = RCP_SIN;
        div = DW'(DIV_SIN);
      end
      tsce_pkg::OP_COS: begin
        rcp = RCP_COS;
        div = DW'(DIV_COS);
      end
      default: begin
        rcp = RCP_EXP;
        div = DW'(DIV_EXP);
      end
    endcase
  end

  assign qd_low = PRW'(s7_q0_r[RW-1:0]) * PRW'(s7_d_r);
  assign q_fix  = s8_q0_r + MW'(s8_r_r >= RW'(s8_d_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NSTG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r[1] <= c1_nxt;
      for (int i = 2; i <= NSTG; i++) begin
        c_r[i] <= c_r[i-1];
      end

      // term * |x|
      s1_lo_r <= PW'(m_in[HW-1:0]) * PW'(in_beat.xmag);
      s1_hi_r <= PW'(m_in[MW-1:HW]) * PW'(in_beat.xmag);
      s2_m_r  <= fold_mul(s1_lo_r, s1_hi_r);

      // second * |x| for sine and cosine
      s3_m_r  <= s2_m_r;
      s3_lo_r <= PW'(s2_m_r[HW-1:0]) * PW'(c_r[2].xmag);
      s3_hi_r <= PW'(s2_m_r[MW-1:HW]) * PW'(c_r[2].xmag);
      s4_m_r  <= (c_r[3].op == tsce_pkg::OP_EXP) ? s3_m_r : fold_mul(s3_lo_r, s3_hi_r);

      // quotient estimate by reciprocal
      s5_m_r  <= s4_m_r;
      s5_d_r  <= div;
      s5_ll_r <= QW'(s4_m_r[HW-1:0]) * QW'(rcp[HW-1:0]);
      s5_lh_r <= QW'(s4_m_r[HW-1:0]) * QW'(rcp[MW-1:HW]);
      s5_hl_r <= QW'(s4_m_r[MW-1:HW]) * QW'(rcp[HW-1:0]);
      s5_hh_r <= QW'(s4_m_r[MW-1:HW]) * QW'(rcp[MW-1:HW]);

      s6_m_r   <= s5_m_r;
      s6_d_r   <= s5_d_r;
      s6_hh_r  <= s5_hh_r;
      s6_mid_r <= MIDW'(s5_lh_r) + MIDW'(s5_hl_r) + MIDW'(s5_ll_r[QW-1:HW]);

      s7_m_r  <= s6_m_r;
      s7_d_r  <= s6_d_r;
      s7_q0_r <= MW'(s6_hh_r) + MW'(s6_mid_r >> HW);

      // remainder is below 2d, so its low bits are enough
      s8_q0_r <= s7_q0_r;
      s8_d_r  <= s7_d_r;
      s8_r_r  <= s7_m_r[RW-1:0] - qd_low[RW-1:0];

      tmag_r <= q_fix[TW-1:0];
    end
  end

  assign out_valid     = v_r[NSTG-1];
  assign out_beat.op   = c_r[NSTG].op;
  assign out_beat.xmag = c_r[NSTG].xmag;
  assign out_beat.xneg = c_r[NSTG].xneg;
  assign out_beat.tmag = tmag_r;
  assign out_beat.tneg = c_r[NSTG].tneg;
  assign out_beat.sum  = c_r[NSTG].sum;

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int TERMS      = tsce_pkg::NUM_TERMS_DEF;
  localparam int LATENCY    = 9 * TERMS - 4;
  localparam int HOLD_LEN   = 400;
  localparam int PHASE_LEN  = 300;
  localparam int MAX_PRINTS = 50;

  class series_scoreboard;
    tsce_pkg::out_beat_t expected_q[$];
    int errors;

    // term (q.40) times x (q.28), magnitudes multiplied, truncated toward zero
    static function longint times_x(longint term, longint x);
      longint unsigned a, b, p;
      bit neg;
      neg = (term < 0) != (x < 0);
      a = (term < 0) ? -term : term;
      b = (x < 0) ? -x : x;
      p = (a >> tsce_pkg::X_FRAC) * b + (((a & 64'h0FFF_FFFF) * b) >> tsce_pkg::X_FRAC);
      return neg ? -longint'(p) : longint'(p);
    endfunction

    static function tsce_pkg::out_beat_t series_sum(tsce_pkg::in_beat_t b);
      tsce_pkg::out_beat_t r;
      longint x, term, sum, k, res;
      longint unsigned mag;
      bit sat;
      r = '0;
      sat = 1'b0;
      if (b.opcode == tsce_pkg::OP_NONE) return r;
      x = longint'(b.arg);
      if (x > longint'(tsce_pkg::ARG_MAX)) x = longint'(tsce_pkg::ARG_MAX);
      if (x < longint'(tsce_pkg::ARG_MIN)) x = longint'(tsce_pkg::ARG_MIN);
      term = (b.opcode == tsce_pkg::OP_SIN) ? x * 4096
                                            : (longint'(1) <<< tsce_pkg::TERM_FRAC);
      sum = term;
      for (int n = 1; n < TERMS; n++) begin
        if (b.opcode == tsce_pkg::OP_EXP) begin
          term = times_x(term, x) / longint'(n);
        end else begin
          k = (b.opcode == tsce_pkg::OP_SIN) ? 2 * n : 2 * n - 1;
          term = -(times_x(times_x(term, x), x) / (k * (k + 1)));
        end
        sum += term;
      end
      mag = (unsigned'((sum < 0) ? -sum : sum) + (64'd1 << (tsce_pkg::ROUND_SH - 1)))
            >> tsce_pkg::ROUND_SH;
      if (sum < 0) begin
        if (mag > 64'h8000_0000) begin
          mag = 64'h8000_0000;
          sat = 1'b1;
        end
        res = -longint'(mag);
      end else begin
        if (mag > 64'h7FFF_FFFF) begin
          mag = 64'h7FFF_FFFF;
          sat = 1'b1;
        end
        res = longint'(mag);
      end
      r.value = tsce_pkg::VAL_W'(res);
      r.saturated = sat;
      return r;
    endfunction

    function void note_input(tsce_pkg::in_beat_t b);
      expected_q.push_back(series_sum(b));
    endfunction

    task report(string what);
      errors++;
      if (errors <= MAX_PRINTS) $display("mismatch: %s", what);
    endtask

    task check_result(tsce_pkg::out_beat_t got);
      tsce_pkg::out_beat_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result value=%h sat=%b", got.value, got.saturated));
        return;
      end
      want = expected_q.pop_front();
      if (got.value !== want.value)
        report($sformatf("value got %h want %h", got.value, want.value));
      if (got.saturated !== want.saturated)
        report($sformatf("saturated got %b want %b", got.saturated, want.saturated));
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  tsce_pkg::in_beat_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  tsce_pkg::out_beat_t out_data;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int hold_done = 0;

  series_scoreboard sb = new();

  taylor_series_sin_cos_exp #(.NUM_TERMS(TERMS)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // receiver: random stalls, or one long hold-off when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req != hold_done) begin
        hold_done = hold_req;
        out_stall <= 1'b1;
        repeat (HOLD_LEN - 1) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic send_beat(input tsce_pkg::in_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    sb.note_input(b);
  endtask

  function automatic tsce_pkg::in_beat_t random_beat();
    tsce_pkg::in_beat_t b;
    int unsigned pick;
    b.opcode = ($urandom_range(15) == 0) ? tsce_pkg::OP_NONE : 2'($urandom_range(2));
    pick = $urandom_range(7);
    if (pick == 0)
      b.arg = $urandom;  // anything, clamped by the block
    else if (pick == 1)
      b.arg = 32'($urandom_range(8191)) - 32'd4096;  // near zero
    else
      b.arg = 32'($urandom_range(32'h8000_0000)) - 32'h4000_0000;
    return b;
  endfunction

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) send_beat(random_beat());
  endtask

  initial begin
    tsce_pkg::in_beat_t b;
    logic signed [tsce_pkg::ARG_W-1:0] edge_args[7];
    edge_args = '{32'sd0, tsce_pkg::ARG_MAX, tsce_pkg::ARG_MIN, 32'sh7FFF_FFFF,
                  32'sh8000_0000, 32'sd1, -32'sd1};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: every function at the argument extremes and near zero, plus the unused opcode
    foreach (edge_args[i]) begin
      b.arg = edge_args[i];
      b.opcode = tsce_pkg::OP_SIN;
      send_beat(b);
      b.opcode = tsce_pkg::OP_COS;
      send_beat(b);
      b.opcode = tsce_pkg::OP_EXP;
      send_beat(b);
    end
    b.opcode = tsce_pkg::OP_NONE;
    b.arg = 32'sh1234_5678;
    send_beat(b);
    b.arg = -32'sd1;
    send_beat(b);

    send_idle_pct = 17;
    recv_idle_pct <= 48;
    run_random(PHASE_LEN);

    send_idle_pct = 48;
    recv_idle_pct <= 17;
    run_random(PHASE_LEN);

    // no idling; a long hold-off fills the pipe while beats keep coming
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    hold_req <= hold_req + 1;
    run_random(PHASE_LEN);
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/tsce_pkg.sv
hdl/tsce_term.sv
hdl/taylor_series_sin_cos_exp.sv
test/tb_top.sv
